/* src/track_score_lifecycle_table_core_defines.svh */
// Assertion macros for the track table core.
`ifndef TRACK_SCORE_LIFECYCLE_TABLE_CORE_DEFINES_SVH
`define TRACK_SCORE_LIFECYCLE_TABLE_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TSLT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Implication checked in the next cycle.
`define TSLT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/tslt_pkg.sv */
package tslt_pkg;

    localparam int MaxTracksDefault = 32;

    localparam logic [31:0] VarLimitReset    = 32'd589824;
    localparam logic [2:0]  ConfirmReset     = 3'd5;
    localparam logic [2:0]  DropReset        = 3'd3;
    localparam logic [10:0] SmoothReset      = 11'd102;

    localparam logic [2:0] OpCreate  = 3'd0;
    localparam logic [2:0] OpHit     = 3'd1;
    localparam logic [2:0] OpMiss    = 3'd2;
    localparam logic [2:0] OpPredict = 3'd3;
    localparam logic [2:0] OpSweep   = 3'd4;

    localparam logic [2:0] KindUpdated = 3'd0;
    localparam logic [2:0] KindCreated = 3'd1;
    localparam logic [2:0] KindDeleted = 3'd2;
    localparam logic [2:0] KindDone    = 3'd3;
    localparam logic [2:0] KindError   = 3'd4;

    localparam logic [1:0] StatusNew       = 2'd0;
    localparam logic [1:0] StatusTentative = 2'd1;
    localparam logic [1:0] StatusConfirmed = 2'd2;

    localparam logic [1:0] RegVarLimit = 2'd0;
    localparam logic [1:0] RegConfirm  = 2'd1;
    localparam logic [1:0] RegDrop     = 2'd2;
    localparam logic [1:0] RegSmooth   = 2'd3;

    localparam int InWidth  = 248;
    localparam int OutWidth = 184;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DECIDE,
        ST_SMOOTH,
        ST_WRITE,
        ST_EMIT,
        ST_SWEEP_READ,
        ST_SWEEP_CHECK,
        ST_SWEEP_EMIT,
        ST_DONE_EMIT
    } state_t;

    // Smoothed size: old + floor((new-old)*w/1024), saturated to 16 bits.
    function automatic logic [15:0] smooth_size(input logic [15:0] old_v,
                                                input logic [15:0] meas,
                                                input logic [10:0] w);
        logic signed [16:0] diff;
        logic signed [28:0] prod;
        logic signed [18:0] q;
        logic signed [19:0] r;
        diff = $signed({1'b0, meas}) - $signed({1'b0, old_v});
        prod = diff * $signed({1'b0, w});
        q    = 19'(prod >>> 10);
        r    = $signed({4'b0, old_v}) + 20'(q);
        if (r < 0) begin
            return 16'd0;
        end else if (r > 20'sd65535) begin
            return 16'hFFFF;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage

/* src/track_score_lifecycle_table_core.sv */
// Channel   | Dir | Payload
// s_axis    | in  | tdata: op, track_id, pos xyz, var xy, box hwl, yaw
// m_axis    | out | tdata: kind..heading; tlast: last
// cfg       | in  | cfg_index, cfg_data
// Create, hit, miss, predict: the id/free-slot scan walks one slot per cycle through a
// single compare unit, then the slot is read and written and the result emitted. Hit
// also passes each of the three sizes in turn through the shared smoothing multiplier.
// Sweep: each slot is read, then checked; a deletion adds an emit step that waits on the output; done word last.
// Reset (aresetn, sync) clears valid bits and next id and reloads config defaults; memories hold.
// A stalled m_tready holds the sequencer; s_tready is low until last is taken.
module track_score_lifecycle_table_core
    import tslt_pkg::*;
#(
    parameter int MAX_TRACKS = MaxTracksDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // op[2:0], track_id, pos_x, pos_y, pos_z, var_x, var_y, box_h, box_w, box_l, yaw
    input  logic [InWidth-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // kind[2:0], out_id, score[3], status[2], loc_x, loc_y, loc_z, h, w, l, heading
    output logic [OutWidth-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    localparam int SW = $clog2(MAX_TRACKS + 1);
    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    logic [31:0] var_limit_reg;
    logic [2:0]  confirm_reg, drop_reg;
    logic [10:0] smooth_w_reg;

    state_t state_reg, state_next;
    logic [SW-1:0] idx_reg;
    logic [InWidth-1:0] in_reg;
    logic [MAX_TRACKS-1:0] valid_reg;
    logic [15:0] next_id_reg;
    logic found_reg, free_found_reg;
    logic [AW-1:0] hit_slot_reg, free_slot_reg;
    logic [1:0] sz_cnt_reg;

    // memories
    logic [15:0]  mem_id     [MAX_TRACKS];
    logic [2:0]   mem_score  [MAX_TRACKS];
    logic [1:0]   mem_status [MAX_TRACKS];
    logic [95:0]  mem_pos    [MAX_TRACKS];
    logic [63:0]  mem_var    [MAX_TRACKS];
    logic [47:0]  mem_size   [MAX_TRACKS];
    logic [15:0]  mem_head   [MAX_TRACKS];

    // registered read data
    logic [15:0] rd_id_reg;
    logic [2:0]  rd_score_reg;
    logic [1:0]  rd_status_reg;
    logic [95:0] rd_pos_reg;
    logic [63:0] rd_var_reg;
    logic [47:0] rd_size_reg;
    logic [15:0] rd_head_reg;

    logic [47:0] new_size_reg;
    logic [OutWidth-1:0] out_reg;
    logic out_last_reg, out_valid_reg;

    logic [2:0]  in_op;
    logic [15:0] in_tid, in_yaw;
    logic [95:0] in_pos;
    logic [63:0] in_var;
    logic [47:0] in_box;
    assign in_op  = in_reg[2:0];
    assign in_tid = in_reg[18:3];
    assign in_pos = in_reg[114:19];
    assign in_var = in_reg[178:115];
    assign in_box = in_reg[226:179];
    assign in_yaw = in_reg[242:227];

    logic [15:0] create_id;
    assign create_id = next_id_reg + 16'd1;

    logic [AW-1:0] idx_a, rd_addr;
    assign idx_a = idx_reg[AW-1:0];
    logic last_slot;
    assign last_slot = (idx_reg == SW'(MAX_TRACKS - 1));

    // shared compare: id match against current slot during scan
    logic [15:0] scan_key;
    assign scan_key = (in_op == OpCreate) ? create_id : in_tid;
    logic slot_match;
    assign slot_match = valid_reg[idx_a] && (mem_id[idx_a] == scan_key);

    logic do_write, err;

    // sweep drop check
    logic drop;
    assign drop = (rd_status_reg == StatusConfirmed && rd_score_reg <= drop_reg)
        || (rd_var_reg[31:0] > var_limit_reg) || (rd_var_reg[63:32] > var_limit_reg)
        || (rd_score_reg == 3'd0);

    // shared smoothing unit, one size per cycle
    logic [15:0] sm_old, sm_new, sm_out;
    always_comb begin
        unique case (sz_cnt_reg)
            2'd0: begin sm_old = rd_size_reg[15:0];  sm_new = in_box[15:0];  end
            2'd1: begin sm_old = rd_size_reg[31:16]; sm_new = in_box[31:16]; end
            default: begin sm_old = rd_size_reg[47:32]; sm_new = in_box[47:32]; end
        endcase
    end
    assign sm_out = smooth_size(sm_old, sm_new, smooth_w_reg);

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    logic out_load;
    assign out_load = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_SWEEP_EMIT)
                                   || (state_reg == ST_DONE_EMIT));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = (s_tdata[2:0] == OpSweep) ? ST_SWEEP_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_slot) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (!err && in_op == OpHit) begin
                    state_next = ST_SMOOTH;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_SMOOTH: begin
                if (sz_cnt_reg == 2'd2) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP_READ:  state_next = ST_SWEEP_CHECK;
            ST_SWEEP_CHECK: begin
                if (valid_reg[idx_a] && drop) begin
                    state_next = ST_SWEEP_EMIT;
                end else if (last_slot) begin
                    state_next = ST_DONE_EMIT;
                end else begin
                    state_next = ST_SWEEP_READ;
                end
            end
            ST_SWEEP_EMIT: begin
                if (out_free) begin
                    state_next = last_slot ? ST_DONE_EMIT : ST_SWEEP_READ;
                end
            end
            ST_DONE_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // error decision for single-result ops
    always_comb begin
        unique case (in_op)
            OpCreate:                   err = !free_found_reg || found_reg;
            OpHit, OpMiss, OpPredict:   err = !found_reg;
            default:                    err = 1'b1;
        endcase
    end
    assign do_write = !err;

    assign rd_addr = (in_op == OpCreate) ? free_slot_reg : hit_slot_reg;

    // outputs
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign m_tlast   = out_last_reg;

    // updated track fields computed in ST_WRITE
    logic [2:0] upd_score;
    logic [1:0] upd_status;
    always_comb begin
        upd_score  = rd_score_reg;
        upd_status = rd_status_reg;
        unique case (in_op)
            OpHit: begin
                upd_score  = (rd_score_reg < 3'd6) ? rd_score_reg + 3'd1 : rd_score_reg;
                upd_status = (upd_score >= confirm_reg) ? StatusConfirmed : StatusTentative;
            end
            OpMiss: begin
                upd_score = (rd_score_reg > 3'd0) ? rd_score_reg - 3'd1 : rd_score_reg;
            end
            OpCreate: begin
                upd_score  = 3'd1;
                upd_status = StatusNew;
            end
            default: ;
        endcase
    end

    logic [95:0] w_pos;
    logic [47:0] w_size;
    logic [15:0] w_head, w_id;
    always_comb begin
        w_pos  = (in_op == OpMiss) ? rd_pos_reg : in_pos;
        w_size = rd_size_reg;
        w_head = rd_head_reg;
        w_id   = (in_op == OpCreate) ? create_id : rd_id_reg;
        if (in_op == OpHit) begin
            w_size = new_size_reg;
            w_head = in_yaw;
        end else if (in_op == OpCreate) begin
            w_size = in_box;
            w_head = in_yaw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            next_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
            var_limit_reg  <= VarLimitReset;
            confirm_reg    <= ConfirmReset;
            drop_reg       <= DropReset;
            smooth_w_reg   <= SmoothReset;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            sz_cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    RegVarLimit: var_limit_reg <= cfg_data;
                    RegConfirm:  confirm_reg   <= cfg_data[2:0];
                    RegDrop:     drop_reg      <= cfg_data[2:0];
                    default:     smooth_w_reg  <= cfg_data[10:0];
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg        <= '0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                    sz_cnt_reg     <= '0;
                end
                ST_SCAN: begin
                    if (slot_match && !found_reg) begin
                        found_reg    <= 1'b1;
                        hit_slot_reg <= idx_a;
                    end
                    if (!valid_reg[idx_a] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= idx_a;
                    end
                    idx_reg <= idx_reg + SW'(1);
                end
                ST_SMOOTH: sz_cnt_reg <= sz_cnt_reg + 2'd1;
                ST_WRITE: begin
                    if (in_op == OpCreate && free_found_reg) begin
                        next_id_reg <= create_id;
                    end
                    if (do_write) begin
                        valid_reg[rd_addr] <= 1'b1;
                    end
                end
                ST_SWEEP_CHECK: begin
                    if (!(valid_reg[idx_a] && drop)) begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                ST_SWEEP_EMIT: begin
                    if (out_free) begin
                        valid_reg[idx_a] <= 1'b0;
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: memory reads, writes, output word
    logic [AW-1:0] mem_raddr;
    assign mem_raddr = (state_reg == ST_SWEEP_READ) ? idx_a : rd_addr;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
            in_reg <= s_tdata;
        end
        if (state_reg == ST_READ || state_reg == ST_SWEEP_READ) begin
            rd_id_reg     <= mem_id[mem_raddr];
            rd_score_reg  <= mem_score[mem_raddr];
            rd_status_reg <= mem_status[mem_raddr];
            rd_pos_reg    <= mem_pos[mem_raddr];
            rd_var_reg    <= mem_var[mem_raddr];
            rd_size_reg   <= mem_size[mem_raddr];
            rd_head_reg   <= mem_head[mem_raddr];
        end
        if (state_reg == ST_SMOOTH) begin
            unique case (sz_cnt_reg)
                2'd0:    new_size_reg[15:0]  <= sm_out;
                2'd1:    new_size_reg[31:16] <= sm_out;
                default: new_size_reg[47:32] <= sm_out;
            endcase
        end
        if (state_reg == ST_WRITE) begin
            if (do_write) begin
                mem_id[rd_addr]     <= w_id;
                mem_score[rd_addr]  <= upd_score;
                mem_status[rd_addr] <= upd_status;
                mem_pos[rd_addr]    <= w_pos;
                mem_var[rd_addr]    <= (in_op == OpMiss) ? rd_var_reg : in_var;
                mem_size[rd_addr]   <= w_size;
                mem_head[rd_addr]   <= w_head;
                out_reg <= {w_head, w_size, w_pos, upd_status, upd_score, w_id,
                            (in_op == OpCreate) ? KindCreated : KindUpdated};
            end else begin
                out_reg <= {165'd0,
                            (in_op == OpCreate) ? create_id : in_tid, KindError};
            end
            out_last_reg <= 1'b1;
        end
        if (state_reg == ST_SWEEP_EMIT && out_free) begin
            out_reg <= {rd_head_reg, rd_size_reg, rd_pos_reg, rd_status_reg,
                        rd_score_reg, rd_id_reg, KindDeleted};
            out_last_reg <= 1'b0;
        end
        if (state_reg == ST_DONE_EMIT && out_free) begin
            out_reg      <= {165'd0, 16'd0, KindDone};
            out_last_reg <= 1'b1;
        end
    end

endmodule

/* src/tslt_checker.sv */
`include "track_score_lifecycle_table_core_defines.svh"
module tslt_checker
    import tslt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutWidth-1:0] m_tdata,
    input logic                m_tlast
);
    `TSLT_ASSERT_IMPL(a_no_accept_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `TSLT_ASSERT_IMPL(a_done_is_last, aclk, aresetn, m_tvalid && m_tdata[2:0] == KindDone, m_tlast)
    `TSLT_ASSERT_IMPL(a_deleted_not_last, aclk, aresetn, m_tvalid && m_tdata[2:0] == KindDeleted, !m_tlast)
    `TSLT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind track_score_lifecycle_table_core tslt_checker u_tslt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
